/* design/b64e_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character codes and the alphabet lookup for the base64
// line-wrapped encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    // Groups of four characters on one 76-column line
    localparam logic [4:0] GROUPS_PER_LINE = 5'd19;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    // Encoder state carried between items
    typedef struct packed {
        logic [1:0]  phase;    // bytes pending in the current group
        logic [15:0] pending;  // first byte in [15:8], second in [7:0]
        logic [4:0]  groups;   // complete groups on the current line
        logic        started;  // something already emitted in this message
    } enc_state_t;

    // One group of characters handed to the serialiser
    typedef struct packed {
        logic            has_out;  // item produces characters
        logic            crlf;     // line break precedes the group
        logic [3:0][7:0] chars;    // chars[0] goes out first
        logic            last;     // fourth char closes the message
    } group_rec_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] r;
        begin
            if (v < 6'd26)
                r = 8'd65 + {2'b00, v};
            else if (v < 6'd52)
                r = 8'd97 + {2'b00, v} - 8'd26;
            else if (v < 6'd62)
                r = 8'd48 + {2'b00, v} - 8'd52;
            else if (v == 6'd62)
                r = 8'd43;
            else
                r = 8'd47;
            return r;
        end
    endfunction

endpackage

/* design/b64e_group.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_group
// Combinational group former: from the held state and one input item it
// builds the next state and the group of characters, if any.
// ----------------------------------------------------------------------------
module b64e_group
    import b64e_pkg::*;
(
    input  enc_state_t  st,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output enc_state_t  st_next,
    output group_rec_t  rec
);

    logic [1:0] phase;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       crlf;
    logic [4:0] groups_open;

    // Phase three never arises; treat as empty
    assign phase = (st.phase == 2'd3) ? 2'd0 : st.phase;
    assign b0    = st.pending[15:8];
    assign b1    = st.pending[7:0];

    // Line break once the line holds a full 76 columns
    assign crlf        = st.started && (st.groups >= GROUPS_PER_LINE);
    assign groups_open = (crlf ? 5'd0 : st.groups) + 5'd1;

    always_comb
    begin
        st_next     = st;
        rec.has_out = 1'b0;
        rec.crlf    = crlf;
        rec.last    = end_of_message;
        rec.chars   = '0;

        if (phase == 2'd2)
        begin
            // Full group of three bytes
            rec.has_out    = 1'b1;
            rec.chars[0]   = sym(b0[7:2]);
            rec.chars[1]   = sym({b0[1:0], b1[7:4]});
            rec.chars[2]   = sym({b1[3:0], data_byte[7:6]});
            rec.chars[3]   = sym(data_byte[5:0]);
            st_next.phase   = 2'd0;
            st_next.pending = 16'd0;
            st_next.groups  = groups_open;
            st_next.started = 1'b1;
        end
        else if (!end_of_message)
        begin
            // Hold the byte until the group completes
            if (phase == 2'd0)
                st_next.pending = {data_byte, 8'd0};
            else
                st_next.pending = {b0, data_byte};
            st_next.phase = phase + 2'd1;
        end
        else if (phase == 2'd1)
        begin
            // Two-byte tail, one pad
            rec.has_out  = 1'b1;
            rec.chars[0] = sym(b0[7:2]);
            rec.chars[1] = sym({b0[1:0], data_byte[7:4]});
            rec.chars[2] = sym({data_byte[3:0], 2'b00});
            rec.chars[3] = CHAR_PAD;
        end
        else
        begin
            // One-byte tail, two pads
            rec.has_out  = 1'b1;
            rec.chars[0] = sym(data_byte[7:2]);
            rec.chars[1] = sym({data_byte[1:0], 4'd0});
            rec.chars[2] = CHAR_PAD;
            rec.chars[3] = CHAR_PAD;
        end

        // Message closed: back to a fresh line
        if (end_of_message)
            st_next = '0;
    end

endmodule

/* design/b64e_serial.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_serial
// Result register: holds up to six characters of one group (with optional
// CR LF) and hands them out one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module b64e_serial
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  group_rec_t  rec,
    output logic        load_ok,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // last_char
);

    logic [5:0][7:0] slot_reg;
    logic [5:0][7:0] slot_next;
    logic [2:0]      count_reg;
    logic [2:0]      count_next;
    logic            last_reg;
    logic            last_next;
    logic            take;

    assign m_tvalid = (count_reg != 3'd0);
    assign take     = m_tvalid && m_tready;
    assign load_ok  = (count_reg == 3'd0) || ((count_reg == 3'd1) && m_tready);
    assign m_tdata  = slot_reg[0];
    assign m_tlast  = last_reg && (count_reg == 3'd1);

    // Load a new group or shift out one character
    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        last_next  = last_reg;
        if (load)
        begin
            last_next = rec.last;
            if (rec.crlf)
            begin
                slot_next  = {rec.chars[3], rec.chars[2], rec.chars[1], rec.chars[0],
                              CHAR_LF, CHAR_CR};
                count_next = 3'd6;
            end
            else
            begin
                slot_next  = {16'd0, rec.chars[3], rec.chars[2], rec.chars[1],
                              rec.chars[0]};
                count_next = 3'd4;
            end
        end
        else if (take)
        begin
            slot_next  = {8'd0, slot_reg[5:1]};
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

/* design/base64_line_wrapped_encoder_core.sv */
`timescale 1ns / 1ps
// An item is registered in the input register on acceptance; its characters
// are loaded into the result register once that register is free and go out
// from it one per cycle while the sink is ready.
// One item is taken per cycle while items give no characters; a group
// occupies the one-character output until its four characters, or six with
// CR LF, have gone out.
// Reset (rst_n low, asynchronous) empties both registers and starts a fresh line.
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_core
// Base64 encoder with CR LF line breaks every 76 characters.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_core
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // last_char
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    enc_state_t st_reg;
    enc_state_t st_next;
    enc_state_t st_calc;
    group_rec_t rec;
    logic       load_ok;
    logic       proc_fire;
    logic       s_take;

    // Item leaves the input register once the result register can take it
    assign proc_fire = in_valid_reg && (!rec.has_out || load_ok);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_take    = s_tvalid && s_tready;

    assign in_valid_next = s_take || (in_valid_reg && !proc_fire);
    assign st_next       = proc_fire ? st_calc : st_reg;

    b64e_group u_group (
        .st             (st_reg),
        .data_byte      (in_byte_reg),
        .end_of_message (in_last_reg),
        .st_next        (st_calc),
        .rec            (rec)
    );

    b64e_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (proc_fire && rec.has_out),
        .rec      (rec),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Control and encoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            st_reg       <= st_next;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

/* design/b64e_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the encoder output, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker
    import b64e_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic alpha_char;
    logic m_take;

    assign m_take     = m_tvalid && m_tready;
    assign alpha_char = ((m_tdata >= 8'd65) && (m_tdata <= 8'd90)) ||
                        ((m_tdata >= 8'd97) && (m_tdata <= 8'd122)) ||
                        ((m_tdata >= 8'd48) && (m_tdata <= 8'd57)) ||
                        (m_tdata == 8'd43) || (m_tdata == 8'd47);

    // Stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output item changed under stall");

    // Only alphabet, pad, CR or LF
    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (alpha_char || (m_tdata == CHAR_PAD) ||
                      (m_tdata == CHAR_CR) || (m_tdata == CHAR_LF)))
        else $error("character outside the output set");

    // Closing character is never part of a line break
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> ((m_tdata != CHAR_CR) && (m_tdata != CHAR_LF)))
        else $error("line break marked last");

    // CR is followed at once by LF
    a_crlf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_take && (m_tdata == CHAR_CR)) |=> (m_tvalid && (m_tdata == CHAR_LF)))
        else $error("CR not followed by LF");

endmodule

bind base64_line_wrapped_encoder_core b64e_checker u_b64e_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
